/* sv/qpht_pkg.sv */
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants for the quadratic probing hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int OP_W         = 2;
  localparam int KEY_W        = 31;
  localparam int STATUS_W     = 3;
  localparam int SLOT_W       = 4;
  localparam int TABLE_SIZE_D = 13;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_CHECK = 5'b10000
  } state_t;

endpackage

/* sv/quadratic_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressed hash table with quadratic probing: insert, delete, search.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; one result
// follows with done high for a single cycle and cannot be stalled. The home
// slot is found first, by a reciprocal multiply and then a subtract; each
// probe then reads the slot memory and checks the word, with at most
// TABLE_SIZE probes per operation. Busy drops with done, so a new operation
// can be taken while done is high. An unused op code is answered straight
// from idle, with no probe. After reset the table memory is swept clear,
// with busy high.
module quadratic_probe_hash_table
  import qpht_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_D
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op,
  input  logic [KEY_W-1:0]    key,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int SUM_W  = IDX_W + 2;
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int REC_W  = KEY_W + 1;
  localparam int PROD_W = KEY_W + REC_W;
  localparam int Q_W    = REC_W - IDX_W;
  localparam int WORD_W = KEY_W + 1;

  localparam logic [REC_W-1:0] RECIP   =
    REC_W'(((64'd1 << (KEY_W + IDX_W)) / 64'(TABLE_SIZE)) + 64'd1);
  localparam logic [SUM_W-1:0] N_SUM   = SUM_W'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] N_CNT   = CNT_W'(TABLE_SIZE);

  state_t state, state_next;

  logic [WORD_W-1:0] mem [TABLE_SIZE];
  logic [WORD_W-1:0] rd_word;

  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [PROD_W-1:0] prod;
  logic              step;
  logic [Q_W-1:0]    quot;
  logic [Q_W-1:0]    quot_mul;
  logic [IDX_W-1:0]  hash_rem;
  logic [IDX_W-1:0]  home;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [IDX_W-1:0]  delta;
  logic [IDX_W-1:0]  delta_next;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  clr_idx;

  logic              hit;
  logic              last;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_waddr;

  // home slot: key - floor(key / TABLE_SIZE) * TABLE_SIZE, quotient by reciprocal
  assign quot     = prod[PROD_W-1:KEY_W+IDX_W];
  assign quot_mul = quot * Q_W'(TABLE_SIZE);
  assign hash_rem = key_q[IDX_W-1:0] - quot_mul[IDX_W-1:0];

  // next probe: idx + (2i-1), delta advances by two, both mod TABLE_SIZE
  always_comb begin
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] d;
    s = SUM_W'(idx) + SUM_W'(delta);
    if (s >= N_SUM) begin
      s = s - N_SUM;
    end
    d = SUM_W'(delta) + SUM_W'(2);
    if (d >= N_SUM) begin
      d = d - N_SUM;
    end
    idx_next   = s[IDX_W-1:0];
    delta_next = d[IDX_W-1:0];
  end

  assign last = (cnt == N_CNT) || (idx_next == home);

  always_comb begin
    if (op_q == OP_INSERT) begin
      hit = !rd_word[KEY_W];
    end else begin
      hit = rd_word[KEY_W] && (rd_word[KEY_W-1:0] == key_q);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
    end else if (state == S_CHECK && hit && op_q != OP_SEARCH) begin
      mem_we = 1'b1;
      if (op_q == OP_INSERT) begin
        mem_wdata = {1'b1, key_q};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_READ) begin
      rd_word <= mem[idx];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_idx == LAST_IX) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (op == OP_INSERT || op == OP_DELETE || op == OP_SEARCH) begin
            state_next = S_HASH;
          end
        end
      end
      S_HASH:  if (step) state_next = S_READ;
      S_READ:  state_next = S_CHECK;
      S_CHECK: state_next = (hit || last) ? S_IDLE : S_READ;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (state == S_IDLE && start &&
          !(op == OP_INSERT || op == OP_DELETE || op == OP_SEARCH)) begin
        done <= 1'b1;
      end
      if (state == S_CHECK && (hit || last)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_q   <= op;
        key_q  <= key;
        step   <= 1'b0;
        status <= ST_NOT_FOUND;
        slot   <= '0;
      end
      S_HASH: begin
        step <= 1'b1;
        if (!step) begin
          prod <= PROD_W'(key_q) * PROD_W'(RECIP);
        end else begin
          home  <= hash_rem;
          idx   <= hash_rem;
          delta <= IDX_W'(1);
          cnt   <= CNT_W'(1);
        end
      end
      S_CHECK: begin
        if (hit) begin
          slot <= SLOT_W'(idx);
          case (op_q)
            OP_INSERT: status <= ST_INSERTED;
            OP_DELETE: status <= ST_DELETED;
            default:   status <= ST_FOUND;
          endcase
        end else if (last) begin
          slot   <= '0;
          status <= (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end else begin
          idx   <= idx_next;
          delta <= delta_next;
          cnt   <= cnt + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule
